// ----- rtl/pem_pkg.sv -----
// shared types, constants and helpers for the prewitt edge magnitude block
// no dependencies
`default_nettype none
package pem_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int PIX_W        = 8;
    localparam int FW_W         = 11;
    localparam int FH_W         = 13;
    localparam int CFG_W        = 13;
    localparam int GRAD_W       = 11;
    localparam int SQ_W         = 20;
    localparam int SUM_W        = 21;
    localparam int QDEPTH       = 8;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

    // first trial bit of each half of the square root
    localparam logic [16:0] ROOT_BIT_HI = 17'h04000;
    localparam logic [16:0] ROOT_BIT_LO = 17'h00040;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // result kinds carried by one queue item, in emission order
    localparam int EMIT_INNER   = 0;
    localparam int EMIT_ROW_END = 1;
    localparam int EMIT_BORDER  = 2;

    typedef struct packed {
        logic [PIX_W-1:0] val;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [2:0]       emit;
        logic             last;
    } t_item;

    typedef struct packed {
        logic                     valid;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic [2:0]               emit;
        logic                     interior;
        logic                     last;
    } t_grad;

    // partial state of the digit-by-digit square root
    typedef struct packed {
        logic [16:0] rem;
        logic [16:0] res;
    } t_root;

    // four digits of the square root of a 16-bit value
    function automatic t_root sqrt_steps(input t_root s, input logic [16:0] start);
        t_root       o;
        logic [16:0] bitv;
        o    = s;
        bitv = start;
        for (int i = 0; i < 4; i++) begin
            if (o.rem >= o.res + bitv) begin
                o.rem = o.rem - (o.res + bitv);
                o.res = (o.res >> 1) + bitv;
            end else begin
                o.res = o.res >> 1;
            end
            bitv = bitv >> 2;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pem_ram.sv -----
// generic single-write, single-read ram with registered read (read-first)
// no dependencies
`default_nettype none
module pem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/pem_front.sv -----
// front end: config, raster counters, line store, 3x3 window and gradients
// depends on pem_pkg and pem_ram
`default_nettype none
module pem_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire pem_pkg::t_reg_idx       i_cfg_index,
    input  wire logic [pem_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                    i_valid,
    input  wire logic [pem_pkg::PIX_W-1:0] i_pixel,
    input  wire logic                    i_space_ok,
    output logic                         o_ready,
    output logic                         o_stage_busy,
    output pem_pkg::t_grad               o_grad
);
    import pem_pkg::*;

    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;

    // stage a: pixel waiting for its line store data
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_pix;
    logic [ROW_W-1:0] r_a_row;
    logic [COL_W-1:0] r_a_col;
    logic [2:0]       r_a_emit;
    logic             r_a_interior;
    logic             r_a_last;
    logic             r_a_hit;
    logic [PIX_W-1:0] r_fwd_mid, r_fwd_top;

    logic [PIX_W-1:0] r_win [6];
    t_grad            r_grad;

    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic             accept;
    logic [2:0]       emit;
    logic [PIX_W-1:0] ram_mid, ram_top, a_mid, a_top;
    logic [9:0]       left_sum, right_sum, top_sum, bot_sum;

    always_comb begin
        if (r_fw == '0) begin
            w_eff = FW_W'(1);
        end else if (r_fw > FW_W'(MAX_WIDTH)) begin
            w_eff = FW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_fw;
        end
        if (r_fh == '0) begin
            h_eff = FH_W'(1);
        end else if (r_fh > FH_W'(HEIGHT_LIMIT)) begin
            h_eff = FH_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_fh;
        end
    end

    assign wm1 = COL_W'(w_eff - FW_W'(1));
    assign hm1 = ROW_W'(h_eff - FH_W'(1));

    // a register write restarts the frame, so no pixel is taken in that cycle
    assign o_ready      = i_space_ok && !i_cfg_we;
    assign accept       = i_valid && o_ready;
    assign o_stage_busy = r_a_valid;

    always_comb begin
        emit               = '0;
        emit[EMIT_INNER]   = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(1));
        emit[EMIT_ROW_END] = (r_row >= ROW_W'(2)) && (r_col == wm1);
        emit[EMIT_BORDER]  = (r_row == '0) || (r_row == hm1);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (r_col == wm1) begin
            n_col = '0;
            n_row = (r_row == hm1) ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= WIDTH_RESET;
            r_fh  <= HEIGHT_RESET;
            r_row <= '0;
            r_col <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_fw <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_fh <= i_cfg_data[FH_W-1:0];
                default:          r_fw <= r_fw;
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // row one back lives in mid, row two back in top
    pem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_line (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata (r_a_pix),
        .i_raddr (r_col),
        .o_rdata (ram_mid)
    );

    pem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_line (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata (a_mid),
        .i_raddr (r_col),
        .o_rdata (ram_top)
    );

    // one-column frames read the entry written in the same cycle
    assign a_mid = r_a_hit ? r_fwd_mid : ram_mid;
    assign a_top = r_a_hit ? r_fwd_top : ram_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept && !i_cfg_we;
        end
        r_a_pix      <= i_pixel;
        r_a_row      <= r_row;
        r_a_col      <= r_col;
        r_a_emit     <= emit;
        r_a_interior <= r_col >= COL_W'(2);
        r_a_last     <= (r_row == hm1) && (r_col == wm1);
        r_a_hit      <= r_a_valid && (r_a_col == r_col);
        r_fwd_mid    <= r_a_pix;
        r_fwd_top    <= a_mid;
    end

    assign left_sum  = 10'(r_win[0]) + 10'(r_win[1]) + 10'(r_win[2]);
    assign right_sum = 10'(a_top) + 10'(a_mid) + 10'(r_a_pix);
    assign top_sum   = 10'(r_win[0]) + 10'(r_win[3]) + 10'(a_top);
    assign bot_sum   = 10'(r_win[2]) + 10'(r_win[5]) + 10'(r_a_pix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
            r_grad.valid <= 1'b0;
        end else begin
            if (r_a_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= a_top;
                r_win[4] <= a_mid;
                r_win[5] <= r_a_pix;
            end
            r_grad.valid <= r_a_valid && (r_a_emit != '0);
        end
        r_grad.gx       <= $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
        r_grad.gy       <= $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        r_grad.row      <= r_a_row;
        r_grad.col      <= r_a_col;
        r_grad.emit     <= r_a_emit;
        r_grad.interior <= r_a_interior;
        r_grad.last     <= r_a_last;
    end

    assign o_grad = r_grad;
endmodule
`default_nettype wire

// ----- rtl/pem_mag.sv -----
// magnitude pipeline: squares, then clamped integer square root over two stages
// depends on pem_pkg
`default_nettype none
module pem_mag (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pem_pkg::t_grad i_grad,
    output logic [2:0]          o_busy,
    output logic                o_push,
    output pem_pkg::t_item      o_item
);
    import pem_pkg::*;

    logic              r_s_valid;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [ROW_W-1:0]  r_s_row;
    logic [COL_W-1:0]  r_s_col;
    logic [2:0]        r_s_emit;
    logic              r_s_interior;
    logic              r_s_last;
    logic              r_h_valid;
    t_root             r_h_root;
    logic              r_h_sat;
    logic [ROW_W-1:0]  r_h_row;
    logic [COL_W-1:0]  r_h_col;
    logic [2:0]        r_h_emit;
    logic              r_h_interior;
    logic              r_h_last;
    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [SUM_W-1:0]  sum;
    t_root             root_in, root_hi, root_lo;
    logic [PIX_W-1:0]  root;
    t_item             r_item;
    logic              r_push;

    assign prod_x = i_grad.gx * i_grad.gx;
    assign prod_y = i_grad.gy * i_grad.gy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_push    <= 1'b0;
        end else begin
            r_s_valid <= i_grad.valid;
            r_h_valid <= r_s_valid;
            r_push    <= r_h_valid;
        end
        r_sqx        <= prod_x[SQ_W-1:0];
        r_sqy        <= prod_y[SQ_W-1:0];
        r_s_row      <= i_grad.row;
        r_s_col      <= i_grad.col;
        r_s_emit     <= i_grad.emit;
        r_s_interior <= i_grad.interior;
        r_s_last     <= i_grad.last;
    end

    assign sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);

    always_comb begin
        root_in.rem = {1'b0, sum[15:0]};
        root_in.res = '0;
    end

    assign root_hi = sqrt_steps(root_in, ROOT_BIT_HI);

    always_ff @(posedge i_clk) begin
        // anything from 256 squared up clamps to full scale
        r_h_sat      <= sum[SUM_W-1:16] != '0;
        r_h_root     <= root_hi;
        r_h_row      <= r_s_row;
        r_h_col      <= r_s_col;
        r_h_emit     <= r_s_emit;
        r_h_interior <= r_s_interior;
        r_h_last     <= r_s_last;
    end

    assign root_lo = sqrt_steps(r_h_root, ROOT_BIT_LO);
    assign root    = r_h_sat ? 8'hFF : root_lo.res[7:0];

    always_ff @(posedge i_clk) begin
        r_item.val  <= r_h_interior ? root : '0;
        r_item.row  <= r_h_row;
        r_item.col  <= r_h_col;
        r_item.emit <= r_h_emit;
        r_item.last <= r_h_last;
    end

    assign o_busy = {r_push, r_h_valid, r_s_valid};
    assign o_push = r_push;
    assign o_item = r_item;
endmodule
`default_nettype wire

// ----- rtl/pem_queue.sv -----
// short flop-based fifo between the gradient pipeline and the result emitter
// depends on pem_pkg
`default_nettype none
module pem_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire pem_pkg::t_item           i_item,
    input  wire logic                     i_pop,
    output logic                          o_valid,
    output pem_pkg::t_item                o_head,
    output logic [pem_pkg::QCNT_W-1:0]    o_count
);
    import pem_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;
endmodule
`default_nettype wire

// ----- rtl/pem_back.sv -----
// result emitter: expands each queued item into its results, one per request
// depends on pem_pkg
`default_nettype none
module pem_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire pem_pkg::t_item i_head,
    output logic                o_pop,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output logic [31:0]         o_tdata,
    output logic                o_tlast
);
    import pem_pkg::*;

    logic [2:0]       r_done;
    logic             r_ov;
    logic [PIX_W-1:0] r_val;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_last;
    logic             out_free, load;
    logic [2:0]       pend, pick;
    logic [PIX_W-1:0] n_val;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;
    logic             n_last;

    assign out_free = !r_ov || i_tready;
    assign pend     = i_head.emit & ~r_done;
    assign load     = out_free && i_q_valid;
    assign o_pop    = load && ((pend & ~pick) == '0);

    always_comb begin
        pick   = '0;
        n_val  = '0;
        n_row  = i_head.row;
        n_col  = i_head.col;
        n_last = 1'b0;
        priority if (pend[EMIT_INNER]) begin
            pick[EMIT_INNER] = 1'b1;
            n_val = i_head.val;
            n_row = i_head.row - ROW_W'(1);
            n_col = i_head.col - COL_W'(1);
        end else if (pend[EMIT_ROW_END]) begin
            pick[EMIT_ROW_END] = 1'b1;
            n_row = i_head.row - ROW_W'(1);
        end else if (pend[EMIT_BORDER]) begin
            pick[EMIT_BORDER] = 1'b1;
            n_last = i_head.last;
        end else begin
            pick = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_done <= '0;
        end else begin
            if (load) begin
                r_ov   <= 1'b1;
                r_done <= o_pop ? 3'b000 : (r_done | pick);
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
        end
        if (load) begin
            r_val  <= n_val;
            r_row  <= n_row;
            r_col  <= n_col;
            r_last <= n_last;
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {2'b00, r_col, r_row, r_val};
    assign o_tlast  = r_last;
endmodule
`default_nettype wire

// ----- rtl/prewitt_edge_magnitude.sv -----
// path: an accepted pixel passes stage a, then the gradient, squares, root and item
//   registers, the queue and the emitter's output register; throughput: one pixel per
//   clock while each gives at most one result and the queue has room; the last
//   row adds a border result per pixel and a row end one, held in the eight-entry queue
// reset: synchronous active-low; width 640, height 480, counters and window zero
// line store contents are undefined until written and need no clearing
`default_nettype none
module prewitt_edge_magnitude (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire pem_pkg::t_reg_idx         i_cfg_index,
    input  wire logic [pem_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [7:0]                i_s_tdata,  // [7:0] pixel
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [31:0]                    o_m_tdata,  // [7:0] edge_res, [19:8] out_row,
                                                       // [29:20] out_col, zero above
    output logic                           o_m_tlast   // frame_end
);
    import pem_pkg::*;

    t_grad             grad;
    t_item             push_item, head;
    logic              a_busy, push, q_valid, pop, space_ok;
    logic [2:0]        mag_busy;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W+1:0] committed;

    // queue entries plus items still in flight must fit
    assign committed = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(a_busy) + (QCNT_W+2)'(grad.valid)
                     + (QCNT_W+2)'(mag_busy[0]) + (QCNT_W+2)'(mag_busy[1])
                     + (QCNT_W+2)'(mag_busy[2]);
    assign space_ok  = committed < (QCNT_W+2)'(QDEPTH);

    pem_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_tvalid),
        .i_pixel      (i_s_tdata),
        .i_space_ok   (space_ok),
        .o_ready      (o_s_tready),
        .o_stage_busy (a_busy),
        .o_grad       (grad)
    );

    pem_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grad  (grad),
        .o_busy  (mag_busy),
        .o_push  (push),
        .o_item  (push_item)
    );

    pem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    pem_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tlast   (o_m_tlast)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (q_count < QCNT_W'(QDEPTH)))
        else $error("queue overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (q_count != '0))
        else $error("pop from empty queue");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= (QCNT_W+2)'(QDEPTH))
        else $error("in-flight items exceed queue space");
endmodule
`default_nettype wire

// ----- tb/sv/pem_checker.sv -----
// checker for prewitt_edge_magnitude: watches the pixel, result and register ports,
// predicts every result from its own frame model and compares field by field
// depends on pem_pkg
`default_nettype none
module pem_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire pem_pkg::t_reg_idx         i_cfg_index,
    input  wire logic [pem_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_s_tvalid,
    input  wire logic                      i_s_tready,
    input  wire logic [7:0]                i_s_tdata,  // [7:0] pixel
    input  wire logic                      i_m_tvalid,
    input  wire logic                      i_m_tready,
    input  wire logic [31:0]               i_m_tdata,  // [7:0] edge_res, [19:8] out_row,
                                                       // [29:20] out_col
    input  wire logic                      i_m_tlast,  // frame_end
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pem_pkg::*;

    typedef struct {
        logic [7:0]  mag;
        logic [11:0] row;
        logic [9:0]  col;
        logic        fend;
    } t_edge_res;

    t_edge_res   edge_q[$];
    logic [7:0]  prev_rows[2][MAX_WIDTH];
    logic [7:0]  win[6];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    function automatic logic [7:0] grad_mag(input int gx, input int gy);
        int unsigned sq;
        int unsigned r;
        int unsigned t;
        sq = gx * gx + gy * gy;
        if (sq >= 65536) return 8'd255;
        r = 0;
        for (int b = 7; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= sq) r = t;
        end
        return r[7:0];
    endfunction

    function automatic void push_edge(input int unsigned mag, input int unsigned row,
                                      input int unsigned col, input logic fend);
        t_edge_res e;
        e.mag  = mag[7:0];
        e.row  = row[11:0];
        e.col  = col[9:0];
        e.fend = fend;
        edge_q.push_back(e);
    endfunction

    task automatic predict_pixel(input logic [7:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned mag;
        logic [7:0]  top;
        logic [7:0]  mid;
        logic        fend;
        int          gx;
        int          gy;
        w = width_reg;
        h = height_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        top = prev_rows[1][c];
        mid = prev_rows[0][c];
        prev_rows[1][c] = mid;
        prev_rows[0][c] = p;
        fend = (r == h - 1 && c == w - 1);
        // interior rows lag one row and one column behind the pixel
        if (r >= 2) begin
            if (c >= 1) begin
                mag = 0;
                if (c >= 2) begin
                    gx = int'(win[0]) + win[1] + win[2] - (int'(top) + mid + p);
                    gy = int'(win[0]) + win[3] + top - (int'(win[2]) + win[5] + p);
                    mag = grad_mag(gx, gy);
                end
                push_edge(mag, r - 1, c - 1, 1'b0);
            end
            if (c == w - 1) push_edge(0, r - 1, w - 1, 1'b0);
        end
        if (r == 0 || r == h - 1) push_edge(0, r, c, fend);
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = p;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_result();
        t_edge_res e;
        if (edge_q.size() == 0) begin
            $display("%0t: unexpected result tdata=%h tlast=%b", $time, i_m_tdata, i_m_tlast);
            o_errors++;
        end else begin
            e = edge_q.pop_front();
            if (i_m_tdata[7:0] !== e.mag) begin
                $display("%0t: edge_res expected %0d actual %0d", $time, e.mag, i_m_tdata[7:0]);
                o_errors++;
            end
            if (i_m_tdata[19:8] !== e.row) begin
                $display("%0t: out_row expected %0d actual %0d", $time, e.row, i_m_tdata[19:8]);
                o_errors++;
            end
            if (i_m_tdata[29:20] !== e.col) begin
                $display("%0t: out_col expected %0d actual %0d", $time, e.col,
                         i_m_tdata[29:20]);
                o_errors++;
            end
            if (i_m_tdata[31:30] !== 2'b00) begin
                $display("%0t: tdata pad expected 0 actual %b", $time, i_m_tdata[31:30]);
                o_errors++;
            end
            if (i_m_tlast !== e.fend) begin
                $display("%0t: frame_end expected %b actual %b", $time, e.fend, i_m_tlast);
                o_errors++;
            end
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            edge_q.delete();
            foreach (prev_rows[i, j]) prev_rows[i][j] = '0;
            foreach (win[i]) win[i] = '0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) width_reg = i_cfg_data[10:0];
                else height_reg = i_cfg_data[12:0];
                row_pos = 0;
                col_pos = 0;
            end
            if (i_s_tvalid && i_s_tready) predict_pixel(i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_result();
        end
        o_pending = edge_q.size();
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb_prewitt_edge_magnitude.sv -----
// top-level testbench for prewitt_edge_magnitude: drives pixels, register writes and
// result backpressure, and reports the verdict from pem_checker
// depends on pem_pkg, pem_checker and the block's rtl
`default_nettype none
module tb_prewitt_edge_magnitude;
    timeunit 1ns;
    timeprecision 1ps;
    import pem_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_reg_idx         i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [31:0]      o_m_tdata;
    logic             o_m_tlast;
    int               errors;
    int               pending;
    int               send_idle_pct;
    int               recv_stall_pct;

    prewitt_edge_magnitude u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    pem_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tlast   (o_m_tlast),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("tb_prewitt_edge_magnitude failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // stop sending, then wait for the block to drain, plus slack for pixels that
    // give no result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= p;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic rand_pixels(input int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: send_pixel(8'h00);
                1: send_pixel(8'hff);
                default: send_pixel(8'($urandom));
            endcase
        end
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int          n;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_FRAME_WIDTH;
        i_cfg_data     = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: first row positions only
        rand_pixels(4);
        // 3x3 frame with a vertical then horizontal step, saturating the magnitude
        set_frame(3, 3);
        for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'hff : 8'h00);
        for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'hff : 8'h00);
        // 4x4 frame with a small gradient
        set_frame(4, 4);
        for (int i = 0; i < 16; i++) send_pixel(8'(i * 3));
        // zero width acts as one column; zero height acts as one row
        set_frame(0, 2);
        rand_pixels(4);
        set_frame(2, 3);
        rand_pixels(7);
        set_frame(5, 0);
        rand_pixels(6);
        // oversized registers clamp to the largest frame
        set_frame(2047, 1);
        rand_pixels(8);
        set_frame(1, 8191);
        rand_pixels(8);
        set_frame(1024, 3);
        rand_pixels(8);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            w = $urandom_range(3, 6);
            h = $urandom_range(3, 5);
            set_frame(w, h);
            n = w * h;
            while (n < 12) n += w * h;
            rand_pixels(n + $urandom_range(0, 3));
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("tb_prewitt_edge_magnitude passed");
        end else begin
            $display("tb_prewitt_edge_magnitude failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
